>>> src/fnms_pkg.sv
// ----------------------------------------------------------------------------
// fnms_pkg
// shared types, codes and default sizes for the face neighbour majority source
// ----------------------------------------------------------------------------
package fnms_pkg;

    localparam int DEF_MAX_VOXELS = 1048576;
    localparam int DEF_MAX_EXTENT = 1024;

    localparam int POS_W  = 10;
    localparam int SIZE_W = 11;
    localparam int ID_W   = 25;
    localparam int IDX_W  = 20;
    localparam int CNT_W  = 21;
    localparam int NB_NUM = 6;
    localparam int NB_W   = 3;
    localparam int HIT_W  = 3;

    localparam logic [1:0] FN_LOAD  = 2'd0;
    localparam logic [1:0] FN_EVAL  = 2'd1;
    localparam logic [1:0] FN_CLEAR = 2'd2;

    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;

    localparam logic [NB_W-1:0] NB_ZM = 3'd0;
    localparam logic [NB_W-1:0] NB_YM = 3'd1;
    localparam logic [NB_W-1:0] NB_XM = 3'd2;
    localparam logic [NB_W-1:0] NB_XP = 3'd3;
    localparam logic [NB_W-1:0] NB_YP = 3'd4;
    localparam logic [NB_W-1:0] NB_ZP = 3'd5;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_RESOLVED   = 2'd1,
        ST_UNRESOLVED = 2'd2,
        ST_RANGE      = 2'd3
    } status_t;

    typedef struct packed {
        logic            capture;
        logic            mul1;
        logic            mul2;
        logic            mul3;
        logic            mem_wr;
        logic            rd_centre;
        logic            rd_nb;
        logic [NB_W-1:0] nb_sel;
        logic            tally;
        logic [NB_W-1:0] tally_sel;
        logic            res_load;
        status_t         res_status;
        logic            res_clear;
    } cmd_t;

    typedef struct packed {
        logic ok;
        logic centre_vacated;
        logic found;
    } dp_stat_t;

endpackage

>>> src/face_neighbor_majority_source.sv
// ----------------------------------------------------------------------------
// face_neighbor_majority_source
// voxel id store that picks a majority face neighbour for vacated voxels
//
// channel   direction  handshake            payload
// in        to block   in_valid/in_ready    func, pos_x, pos_y, pos_z, load_id
// out       from block out_valid/out_ready  status, source_index, totals
// cfg       to block   cfg_we               cfg_index, cfg_data
//
// one item at a time; clear and unused codes go straight to result; loads
// and evaluates pass the three step flat index multiply chain, where out of
// range items stop; a load writes the single port voxel memory, an evaluate
// reads the centre, then for a vacated one its neighbours, one read per cycle
// a result waiting on out_ready holds the block only at its own result step
// reset clears the counters and sets every extent to 1; voxel contents are
// not cleared
// ----------------------------------------------------------------------------
module face_neighbor_majority_source
#(
    parameter int MAX_VOXELS = fnms_pkg::DEF_MAX_VOXELS,
    parameter int MAX_EXTENT = fnms_pkg::DEF_MAX_EXTENT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        func,
    input  logic [fnms_pkg::POS_W-1:0]        pos_x,
    input  logic [fnms_pkg::POS_W-1:0]        pos_y,
    input  logic [fnms_pkg::POS_W-1:0]        pos_z,
    input  logic signed [fnms_pkg::ID_W-1:0]  load_id,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic [fnms_pkg::IDX_W-1:0]        source_index,
    output logic [fnms_pkg::CNT_W-1:0]        resolved_total,
    output logic [fnms_pkg::CNT_W-1:0]        unresolved_total,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [fnms_pkg::SIZE_W-1:0]       cfg_data
);

    fnms_pkg::cmd_t     cmd;
    fnms_pkg::dp_stat_t stat;

    fnms_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    fnms_datapath
    #(
        .MAX_VOXELS (MAX_VOXELS),
        .MAX_EXTENT (MAX_EXTENT)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .pos_z            (pos_z),
        .load_id          (load_id),
        .cmd              (cmd),
        .stat             (stat),
        .status           (status),
        .source_index     (source_index),
        .resolved_total   (resolved_total),
        .unresolved_total (unresolved_total)
    );

endmodule

>>> src/fnms_ctrl.sv
// ----------------------------------------------------------------------------
// fnms_ctrl
// sequencer for load, evaluate and clear items and the result handshake
// ----------------------------------------------------------------------------
module fnms_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    output logic               out_valid,
    input  logic               out_ready,
    output fnms_pkg::cmd_t     cmd,
    input  fnms_pkg::dp_stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_WR,
        S_RDC,
        S_CHK,
        S_NB,
        S_NBL,
        S_FIN,
        S_RES
    } state_t;

    state_t                      state_reg, state_next;
    logic [fnms_pkg::NB_W-1:0]   k_reg, k_next;
    fnms_pkg::status_t           pend_status_reg, pend_status_next;
    logic                        pend_clear_reg, pend_clear_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        func_is_load_reg, func_is_load_next;
    logic                        accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next       = state_reg;
        k_next           = k_reg;
        pend_status_next = pend_status_reg;
        pend_clear_next  = pend_clear_reg;
        cmd              = '0;
        cmd.res_status   = pend_status_reg;
        cmd.res_clear    = pend_clear_reg;
        cmd.nb_sel       = k_reg;
        cmd.tally_sel    = k_reg - fnms_pkg::NB_W'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture      = 1'b1;
                    pend_status_next = fnms_pkg::ST_DONE;
                    pend_clear_next  = (func == fnms_pkg::FN_CLEAR);
                    if (func == fnms_pkg::FN_LOAD || func == fnms_pkg::FN_EVAL)
                    begin
                        state_next = S_MUL1;
                    end
                    else
                    begin
                        state_next = S_RES;
                    end
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul3 = 1'b1;
                if (!stat.ok)
                begin
                    pend_status_next = fnms_pkg::ST_RANGE;
                    state_next       = S_RES;
                end
                else if (pend_clear_reg == 1'b0 && func_is_load_reg)
                begin
                    state_next = S_WR;
                end
                else
                begin
                    state_next = S_RDC;
                end
            end
            S_WR:
            begin
                cmd.mem_wr = 1'b1;
                state_next = S_RES;
            end
            S_RDC:
            begin
                cmd.rd_centre = 1'b1;
                state_next    = S_CHK;
            end
            S_CHK:
            begin
                if (!stat.centre_vacated)
                begin
                    state_next = S_RES;
                end
                else
                begin
                    cmd.rd_nb  = 1'b1;
                    cmd.nb_sel = fnms_pkg::NB_ZM;
                    k_next     = fnms_pkg::NB_YM;
                    state_next = S_NB;
                end
            end
            S_NB:
            begin
                cmd.rd_nb = 1'b1;
                cmd.tally = 1'b1;
                k_next    = k_reg + fnms_pkg::NB_W'(1);
                if (k_reg == fnms_pkg::NB_ZP)
                begin
                    state_next = S_NBL;
                end
            end
            S_NBL:
            begin
                cmd.tally     = 1'b1;
                cmd.tally_sel = fnms_pkg::NB_ZP;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                pend_status_next = stat.found ? fnms_pkg::ST_RESOLVED
                                              : fnms_pkg::ST_UNRESOLVED;
                state_next       = S_RES;
            end
            S_RES:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign func_is_load_next = (state_reg == S_IDLE && accept) ? (func == fnms_pkg::FN_LOAD)
                                                               : func_is_load_reg;

    always_comb
    begin
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            k_reg            <= '0;
            pend_status_reg  <= fnms_pkg::ST_DONE;
            pend_clear_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            func_is_load_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            k_reg            <= k_next;
            pend_status_reg  <= pend_status_next;
            pend_clear_reg   <= pend_clear_next;
            out_valid_reg    <= out_valid_next;
            func_is_load_reg <= func_is_load_next;
        end
    end

endmodule

>>> src/fnms_datapath.sv
// ----------------------------------------------------------------------------
// fnms_datapath
// extent registers, flat index arithmetic, voxel memory, neighbour tally and
// result registers
// ----------------------------------------------------------------------------
module fnms_datapath
#(
    parameter int MAX_VOXELS = fnms_pkg::DEF_MAX_VOXELS,
    parameter int MAX_EXTENT = fnms_pkg::DEF_MAX_EXTENT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [fnms_pkg::SIZE_W-1:0]       cfg_data,
    input  logic [fnms_pkg::POS_W-1:0]        pos_x,
    input  logic [fnms_pkg::POS_W-1:0]        pos_y,
    input  logic [fnms_pkg::POS_W-1:0]        pos_z,
    input  logic signed [fnms_pkg::ID_W-1:0]  load_id,
    input  fnms_pkg::cmd_t                    cmd,
    output fnms_pkg::dp_stat_t                stat,
    output logic [1:0]                        status,
    output logic [fnms_pkg::IDX_W-1:0]        source_index,
    output logic [fnms_pkg::CNT_W-1:0]        resolved_total,
    output logic [fnms_pkg::CNT_W-1:0]        unresolved_total
);

    localparam int AW      = $clog2(MAX_VOXELS);
    localparam int PLANE_W = 2 * fnms_pkg::SIZE_W;
    localparam int ZY_W    = fnms_pkg::SIZE_W + fnms_pkg::POS_W;
    localparam int TOT_W   = 3 * fnms_pkg::SIZE_W;
    localparam int ROW_W   = ZY_W + 1;
    localparam logic [16:0]      EXT_LIM = 17'(MAX_EXTENT);
    localparam logic [TOT_W-1:0] VOX_LIM = TOT_W'(MAX_VOXELS);

    logic [fnms_pkg::SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;

    logic [fnms_pkg::POS_W-1:0]  px_reg, py_reg, pz_reg;
    logic [fnms_pkg::ID_W-1:0]   ld_reg;
    logic [PLANE_W-1:0]          plane_reg;
    logic [ZY_W-1:0]             zy_reg;
    logic [TOT_W-1:0]            total_reg;
    logic [ROW_W-1:0]            row_reg;
    logic [AW-1:0]               flat_reg;
    logic [fnms_pkg::NB_NUM-1:0] mask_reg;
    logic [TOT_W-1:0]            flat_full;

    logic [fnms_pkg::ID_W-1:0]   mem [MAX_VOXELS];
    logic [AW-1:0]               mem_addr, nb_addr, nb_off;
    logic [AW-1:0]               rd_addr_reg;
    logic [fnms_pkg::ID_W-1:0]   rd_data_reg;

    logic [fnms_pkg::ID_W-1:0]   seen_id_reg [fnms_pkg::NB_NUM];
    logic [fnms_pkg::ID_W-1:0]   seen_id_next [fnms_pkg::NB_NUM];
    logic [fnms_pkg::HIT_W-1:0]  hits_reg [fnms_pkg::NB_NUM];
    logic [fnms_pkg::HIT_W-1:0]  hits_next [fnms_pkg::NB_NUM];
    logic [fnms_pkg::NB_W-1:0]   seen_reg, seen_next;
    logic [fnms_pkg::HIT_W-1:0]  most_reg, most_next;
    logic                        found_reg, found_next;
    logic [AW-1:0]               best_reg, best_next;
    logic [fnms_pkg::NB_NUM-1:0] match;
    logic [fnms_pkg::HIT_W-1:0]  cnt;
    logic                        hit;

    logic [fnms_pkg::CNT_W-1:0]  res_cnt_reg, res_cnt_next;
    logic [fnms_pkg::CNT_W-1:0]  unres_cnt_reg, unres_cnt_next;
    fnms_pkg::status_t           status_reg;
    logic [fnms_pkg::IDX_W-1:0]  source_reg;

    // extent registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= fnms_pkg::SIZE_W'(1);
            size_y_reg <= fnms_pkg::SIZE_W'(1);
            size_z_reg <= fnms_pkg::SIZE_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fnms_pkg::CFG_SIZE_X: size_x_reg <= cfg_data;
                fnms_pkg::CFG_SIZE_Y: size_y_reg <= cfg_data;
                fnms_pkg::CFG_SIZE_Z: size_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // flat index and bounds
    assign flat_full = TOT_W'(size_x_reg) * TOT_W'(row_reg) + TOT_W'(px_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
            pz_reg <= pos_z;
            ld_reg <= load_id;
        end
        if (cmd.mul1)
        begin
            plane_reg <= PLANE_W'(size_x_reg) * PLANE_W'(size_y_reg);
            zy_reg    <= ZY_W'(size_y_reg) * ZY_W'(pz_reg);
        end
        if (cmd.mul2)
        begin
            total_reg <= TOT_W'(plane_reg) * TOT_W'(size_z_reg);
            row_reg   <= ROW_W'(zy_reg) + ROW_W'(py_reg);
        end
        if (cmd.mul3)
        begin
            flat_reg    <= AW'(flat_full);
            mask_reg[0] <= (pz_reg != '0);
            mask_reg[1] <= (py_reg != '0);
            mask_reg[2] <= (px_reg != '0);
            mask_reg[3] <= (fnms_pkg::SIZE_W'(px_reg) + fnms_pkg::SIZE_W'(1)) < size_x_reg;
            mask_reg[4] <= (fnms_pkg::SIZE_W'(py_reg) + fnms_pkg::SIZE_W'(1)) < size_y_reg;
            mask_reg[5] <= (fnms_pkg::SIZE_W'(pz_reg) + fnms_pkg::SIZE_W'(1)) < size_z_reg;
        end
    end

    assign stat.ok = (size_x_reg != '0) && (size_y_reg != '0) && (size_z_reg != '0)
                  && (17'(size_x_reg) <= EXT_LIM) && (17'(size_y_reg) <= EXT_LIM)
                  && (17'(size_z_reg) <= EXT_LIM) && (total_reg <= VOX_LIM)
                  && (fnms_pkg::SIZE_W'(px_reg) < size_x_reg)
                  && (fnms_pkg::SIZE_W'(py_reg) < size_y_reg)
                  && (fnms_pkg::SIZE_W'(pz_reg) < size_z_reg);

    assign stat.centre_vacated = rd_data_reg[fnms_pkg::ID_W-1];
    assign stat.found          = found_reg;

    // neighbour address
    always_comb
    begin
        case (cmd.nb_sel)
            fnms_pkg::NB_ZM, fnms_pkg::NB_ZP: nb_off = AW'(plane_reg);
            fnms_pkg::NB_YM, fnms_pkg::NB_YP: nb_off = AW'(size_x_reg);
            default:                          nb_off = AW'(1);
        endcase
        if (cmd.nb_sel == fnms_pkg::NB_ZM || cmd.nb_sel == fnms_pkg::NB_YM
            || cmd.nb_sel == fnms_pkg::NB_XM)
        begin
            nb_addr = flat_reg - nb_off;
        end
        else
        begin
            nb_addr = flat_reg + nb_off;
        end
    end

    assign mem_addr = cmd.rd_nb ? nb_addr : flat_reg;

    // voxel memory
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[mem_addr] <= ld_reg;
        end
        rd_data_reg <= mem[mem_addr];
        rd_addr_reg <= mem_addr;
    end

    // neighbour tally
    always_comb
    begin
        hit = cmd.tally && mask_reg[cmd.tally_sel] && !rd_data_reg[fnms_pkg::ID_W-1];
        cnt = fnms_pkg::HIT_W'(1);
        for (int j = 0; j < fnms_pkg::NB_NUM; j++)
        begin
            match[j] = (fnms_pkg::NB_W'(j) < seen_reg) && (seen_id_reg[j] == rd_data_reg);
            if (match[j])
            begin
                cnt = hits_reg[j] + fnms_pkg::HIT_W'(1);
            end
        end

        seen_id_next = seen_id_reg;
        hits_next    = hits_reg;
        seen_next    = seen_reg;
        most_next    = most_reg;
        found_next   = found_reg;
        best_next    = best_reg;

        if (cmd.rd_centre)
        begin
            seen_next  = '0;
            most_next  = '0;
            found_next = 1'b0;
        end
        else if (hit)
        begin
            if (match != '0)
            begin
                for (int j = 0; j < fnms_pkg::NB_NUM; j++)
                begin
                    if (match[j])
                    begin
                        hits_next[j] = cnt;
                    end
                end
            end
            else if (seen_reg < fnms_pkg::NB_W'(fnms_pkg::NB_NUM))
            begin
                seen_id_next[seen_reg] = rd_data_reg;
                hits_next[seen_reg]    = fnms_pkg::HIT_W'(1);
                seen_next              = seen_reg + fnms_pkg::NB_W'(1);
            end
            if (cnt > most_reg)
            begin
                most_next  = cnt;
                best_next  = rd_addr_reg;
                found_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        seen_id_reg <= seen_id_next;
        hits_reg    <= hits_next;
        best_reg    <= best_next;
    end

    // result counters
    always_comb
    begin
        res_cnt_next   = res_cnt_reg;
        unres_cnt_next = unres_cnt_reg;
        if (cmd.res_load)
        begin
            if (cmd.res_clear)
            begin
                res_cnt_next   = '0;
                unres_cnt_next = '0;
            end
            else if (cmd.res_status == fnms_pkg::ST_RESOLVED && res_cnt_reg != '1)
            begin
                res_cnt_next = res_cnt_reg + fnms_pkg::CNT_W'(1);
            end
            else if (cmd.res_status == fnms_pkg::ST_UNRESOLVED && unres_cnt_reg != '1)
            begin
                unres_cnt_next = unres_cnt_reg + fnms_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            most_reg      <= '0;
            found_reg     <= 1'b0;
            res_cnt_reg   <= '0;
            unres_cnt_reg <= '0;
        end
        else
        begin
            seen_reg      <= seen_next;
            most_reg      <= most_next;
            found_reg     <= found_next;
            res_cnt_reg   <= res_cnt_next;
            unres_cnt_reg <= unres_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_status;
            source_reg <= (cmd.res_status == fnms_pkg::ST_RESOLVED)
                          ? fnms_pkg::IDX_W'(best_reg) : '0;
        end
    end

    assign status           = status_reg;
    assign source_index     = source_reg;
    assign resolved_total   = res_cnt_reg;
    assign unresolved_total = unres_cnt_reg;

endmodule
